/* sv/ecc_pkg.sv */
// ecc_pkg: shared types, constants and the month table of the epoch calendar converter
// used by ecc_dec, ecc_enc and epoch_calendar_converter; no dependencies
package ecc_pkg;

    // pipeline depth, stage 0 takes the input word, last stage drives the outputs
    localparam int STAGES = 9;

    localparam logic [16:0] ZONE_RESET = 17'd28800;

    // 86400 = 675 * 128, the low seven bits go straight through
    localparam int DAY_DIV    = 675;
    localparam int RECIP_DAY  = 50903316;   // floor(2^35 / 675)
    localparam int RECIP_WEEK = 9362;       // floor(2^16 / 7)
    localparam int RECIP_HOUR = 1165;       // floor(2^22 / 3600)
    localparam int RECIP_4Y   = 1435;       // floor(2^21 / 1461)
    localparam int RECIP_MIN  = 1092;       // floor(2^16 / 60)

    localparam int SECS_PER_DAY   = 86400;
    localparam int SECS_PER_HOUR  = 3600;
    localparam int SECS_PER_MIN   = 60;
    localparam int DAYS_TO_2001   = 11323;
    localparam int DAYS_400Y      = 146097;
    localparam int DAYS_100Y      = 36524;
    localparam int DAYS_4Y        = 1461;
    localparam int DAYS_1Y        = 365;
    localparam int WEEK_OFFSET    = 4;      // 1970-01-01 was a thursday
    localparam int EPOCH_2001     = 978307200;

    typedef struct packed {
        logic [6:0] yoc;
        logic [3:0] month;
        logic [4:0] mday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] wday;
    } t_cal;

    // first day of month idx (0 based) within the year, idx 12 is the year length
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
        logic [8:0] base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd365;
        endcase
        return base + 9'((leap && idx >= 4'd2) ? 1 : 0);
    endfunction

endpackage

/* sv/ecc_dec.sv */
// ecc_dec: seconds to calendar datapath, nine register stages
// depends on ecc_pkg; stage enables come from the top level
module ecc_dec (
    input  logic                         i_clk,
    input  logic [ecc_pkg::STAGES-1:0]   i_en,
    input  logic [31:0]                  i_epoch,
    input  logic [16:0]                  i_offset,
    output ecc_pkg::t_cal                o_cal
);

    // stage 0: local seconds
    logic [31:0] n_s0_u;
    logic [24:0] r_s0_x;
    logic [6:0]  r_s0_lo;

    assign n_s0_u = i_epoch + {{15{i_offset[16]}}, i_offset};

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s0_x  <= n_s0_u[31:7];
            r_s0_lo <= n_s0_u[6:0];
        end
    end

    // stage 1: day estimate by reciprocal
    logic [50:0] n_s1_prod;
    logic [15:0] r_s1_q0;
    logic [24:0] r_s1_x;
    logic [6:0]  r_s1_lo;

    assign n_s1_prod = 51'(r_s0_x) * 51'(ecc_pkg::RECIP_DAY);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s1_q0 <= n_s1_prod[50:35];
            r_s1_x  <= r_s0_x;
            r_s1_lo <= r_s0_lo;
        end
    end

    // stage 2: correct the day, seconds of day
    logic [24:0] n_s2_r;
    logic        n_s2_fix;
    logic [24:0] n_s2_rm;
    logic [15:0] r_s2_day;
    logic [16:0] r_s2_rem;

    assign n_s2_r   = r_s1_x - 25'(25'(r_s1_q0) * 25'(ecc_pkg::DAY_DIV));
    assign n_s2_fix = n_s2_r >= 25'(ecc_pkg::DAY_DIV);
    assign n_s2_rm  = n_s2_fix ? n_s2_r - 25'(ecc_pkg::DAY_DIV) : n_s2_r;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s2_day <= r_s1_q0 + 16'(n_s2_fix);
            r_s2_rem <= {n_s2_rm[9:0], r_s1_lo};
        end
    end

    // stage 3: weekday and hour estimates, days from the cycle base
    logic [15:0] n_s3_wv;
    logic [29:0] n_s3_wp;
    logic [26:0] n_s3_hp;
    logic [12:0] r_s3_wq;
    logic [15:0] r_s3_wv;
    logic [4:0]  r_s3_hq;
    logic [16:0] r_s3_rem;
    logic [17:0] r_s3_d0;

    assign n_s3_wv = r_s2_day + 16'(ecc_pkg::WEEK_OFFSET);
    assign n_s3_wp = 30'(n_s3_wv) * 30'(ecc_pkg::RECIP_WEEK);
    assign n_s3_hp = 27'(r_s2_rem) * 27'(ecc_pkg::RECIP_HOUR);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_s3_wq  <= n_s3_wp[28:16];
            r_s3_wv  <= n_s3_wv;
            r_s3_hq  <= n_s3_hp[26:22];
            r_s3_rem <= r_s2_rem;
            // before 2001 count from 1601, the 400 year cycle is never reached
            if (r_s2_day >= 16'(ecc_pkg::DAYS_TO_2001)) begin
                r_s3_d0 <= 18'(r_s2_day) - 18'(ecc_pkg::DAYS_TO_2001);
            end else begin
                r_s3_d0 <= 18'(r_s2_day) + 18'(ecc_pkg::DAYS_400Y - ecc_pkg::DAYS_TO_2001);
            end
        end
    end

    // stage 4: weekday, hour, century
    logic [15:0] n_s4_wr;
    logic [15:0] n_s4_wm;
    logic [16:0] n_s4_hr;
    logic        n_s4_hfix;
    logic [16:0] n_s4_hm;
    logic [1:0]  n_s4_n100;
    logic [2:0]  r_s4_wday;
    logic [4:0]  r_s4_hour;
    logic [11:0] r_s4_r1;
    logic [1:0]  r_s4_n100;
    logic [15:0] r_s4_d1;

    assign n_s4_wr   = r_s3_wv - 16'(16'(r_s3_wq) * 16'd7);
    assign n_s4_wm   = (n_s4_wr >= 16'd7) ? n_s4_wr - 16'd7 : n_s4_wr;
    assign n_s4_hr   = r_s3_rem - 17'(17'(r_s3_hq) * 17'(ecc_pkg::SECS_PER_HOUR));
    assign n_s4_hfix = n_s4_hr >= 17'(ecc_pkg::SECS_PER_HOUR);
    assign n_s4_hm   = n_s4_hfix ? n_s4_hr - 17'(ecc_pkg::SECS_PER_HOUR) : n_s4_hr;

    always_comb begin
        if (r_s3_d0 >= 18'(3 * ecc_pkg::DAYS_100Y)) begin
            n_s4_n100 = 2'd3;
        end else if (r_s3_d0 >= 18'(2 * ecc_pkg::DAYS_100Y)) begin
            n_s4_n100 = 2'd2;
        end else if (r_s3_d0 >= 18'(ecc_pkg::DAYS_100Y)) begin
            n_s4_n100 = 2'd1;
        end else begin
            n_s4_n100 = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_s4_wday <= (n_s4_wm == 16'd0) ? 3'd7 : n_s4_wm[2:0];
            r_s4_hour <= r_s3_hq + 5'(n_s4_hfix);
            r_s4_r1   <= n_s4_hm[11:0];
            r_s4_n100 <= n_s4_n100;
            r_s4_d1   <= 16'(r_s3_d0 - 18'(18'(n_s4_n100) * 18'(ecc_pkg::DAYS_100Y)));
        end
    end

    // stage 5: four year cycle and minute estimates
    logic [26:0] n_s5_np;
    logic [21:0] n_s5_mp;
    logic [4:0]  r_s5_n4q;
    logic [15:0] r_s5_d1;
    logic [1:0]  r_s5_n100;
    logic [5:0]  r_s5_mq;
    logic [11:0] r_s5_r1;
    logic [4:0]  r_s5_hour;
    logic [2:0]  r_s5_wday;

    assign n_s5_np = 27'(r_s4_d1) * 27'(ecc_pkg::RECIP_4Y);
    assign n_s5_mp = 22'(r_s4_r1) * 22'(ecc_pkg::RECIP_MIN);

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_s5_n4q  <= n_s5_np[25:21];
            r_s5_d1   <= r_s4_d1;
            r_s5_n100 <= r_s4_n100;
            r_s5_mq   <= n_s5_mp[21:16];
            r_s5_r1   <= r_s4_r1;
            r_s5_hour <= r_s4_hour;
            r_s5_wday <= r_s4_wday;
        end
    end

    // stage 6: correct four year count and minute
    logic [15:0] n_s6_r;
    logic        n_s6_fix;
    logic [15:0] n_s6_rm;
    logic [11:0] n_s6_mr;
    logic        n_s6_mfix;
    logic [11:0] n_s6_mm;
    logic [4:0]  r_s6_n4;
    logic [10:0] r_s6_d2;
    logic [1:0]  r_s6_n100;
    logic [5:0]  r_s6_min;
    logic [5:0]  r_s6_sec;
    logic [4:0]  r_s6_hour;
    logic [2:0]  r_s6_wday;

    // the day within a century stays below 25 four year cycles, no cap needed
    assign n_s6_r    = r_s5_d1 - 16'(16'(r_s5_n4q) * 16'(ecc_pkg::DAYS_4Y));
    assign n_s6_fix  = n_s6_r >= 16'(ecc_pkg::DAYS_4Y);
    assign n_s6_rm   = n_s6_fix ? n_s6_r - 16'(ecc_pkg::DAYS_4Y) : n_s6_r;
    assign n_s6_mr   = r_s5_r1 - 12'(12'(r_s5_mq) * 12'(ecc_pkg::SECS_PER_MIN));
    assign n_s6_mfix = n_s6_mr >= 12'(ecc_pkg::SECS_PER_MIN);
    assign n_s6_mm   = n_s6_mfix ? n_s6_mr - 12'(ecc_pkg::SECS_PER_MIN) : n_s6_mr;

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_s6_n4   <= r_s5_n4q + 5'(n_s6_fix);
            r_s6_d2   <= n_s6_rm[10:0];
            r_s6_n100 <= r_s5_n100;
            r_s6_min  <= r_s5_mq + 6'(n_s6_mfix);
            r_s6_sec  <= n_s6_mm[5:0];
            r_s6_hour <= r_s5_hour;
            r_s6_wday <= r_s5_wday;
        end
    end

    // stage 7: year within the four year cycle, leap flag, year of century
    logic [1:0]  n_s7_n1;
    logic [6:0]  n_s7_yr;
    logic [8:0]  r_s7_d3;
    logic        r_s7_leap;
    logic [6:0]  r_s7_yoc;
    logic [5:0]  r_s7_min;
    logic [5:0]  r_s7_sec;
    logic [4:0]  r_s7_hour;
    logic [2:0]  r_s7_wday;

    always_comb begin
        if (r_s6_d2 >= 11'(3 * ecc_pkg::DAYS_1Y)) begin
            n_s7_n1 = 2'd3;
        end else if (r_s6_d2 >= 11'(2 * ecc_pkg::DAYS_1Y)) begin
            n_s7_n1 = 2'd2;
        end else if (r_s6_d2 >= 11'(ecc_pkg::DAYS_1Y)) begin
            n_s7_n1 = 2'd1;
        end else begin
            n_s7_n1 = 2'd0;
        end
    end

    // both cycle bases end in 01, so the year of century is 1 + 4*n4 + n1
    assign n_s7_yr = 7'd1 + {r_s6_n4, 2'b00} + 7'(n_s7_n1);

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r_s7_d3   <= 9'(r_s6_d2 - 11'(11'(n_s7_n1) * 11'(ecc_pkg::DAYS_1Y)));
            // last year of a century is leap only in the fourth century
            r_s7_leap <= (n_s7_n1 == 2'd3) && ((r_s6_n4 != 5'd24) || (r_s6_n100 == 2'd3));
            r_s7_yoc  <= (n_s7_yr == 7'd100) ? 7'd0 : n_s7_yr;
            r_s7_min  <= r_s6_min;
            r_s7_sec  <= r_s6_sec;
            r_s7_hour <= r_s6_hour;
            r_s7_wday <= r_s6_wday;
        end
    end

    // stage 8: month walk
    logic [3:0]    n_s8_m;
    logic [8:0]    n_s8_start;
    ecc_pkg::t_cal r_s8_cal;

    always_comb begin
        n_s8_m = 4'd0;
        for (int k = 1; k <= 12; k++) begin
            if (r_s7_d3 >= ecc_pkg::month_start(r_s7_leap, 4'(k))) begin
                n_s8_m = 4'(k);
            end
        end
    end

    assign n_s8_start = ecc_pkg::month_start(r_s7_leap, n_s8_m);

    always_ff @(posedge i_clk) begin
        if (i_en[8]) begin
            r_s8_cal.yoc    <= r_s7_yoc;
            r_s8_cal.month  <= n_s8_m + 4'd1;
            r_s8_cal.mday   <= 5'(r_s7_d3 - n_s8_start + 9'd1);
            r_s8_cal.hour   <= r_s7_hour;
            r_s8_cal.minute <= r_s7_min;
            r_s8_cal.second <= r_s7_sec;
            r_s8_cal.wday   <= r_s7_wday;
        end
    end

    assign o_cal = r_s8_cal;

endmodule

/* sv/ecc_enc.sv */
// ecc_enc: calendar to seconds datapath, three compute stages and a delay line
// depends on ecc_pkg; stage enables come from the top level
module ecc_enc (
    input  logic                         i_clk,
    input  logic [ecc_pkg::STAGES-1:0]   i_en,
    input  logic [6:0]                   i_yoc,
    input  logic [3:0]                   i_month,
    input  logic [4:0]                   i_mday,
    input  logic [4:0]                   i_hour,
    input  logic [5:0]                   i_minute,
    input  logic [5:0]                   i_second,
    input  logic [16:0]                  i_offset,
    output logic [31:0]                  o_seconds
);

    localparam int LAST = ecc_pkg::STAGES - 1;

    // stage 0: day count from 2001-01-01, seconds of day, constant part
    logic               n_s0_leap;
    logic [6:0]         n_s0_y;
    logic signed [17:0] n_s0_base;
    logic [3:0]         n_s0_limit;
    logic [8:0]         n_s0_start;
    logic signed [17:0] r_s0_day;
    logic [16:0]        r_s0_tod;
    logic [31:0]        r_s0_k;

    assign n_s0_leap = (i_yoc[1:0] == 2'b00) && (i_yoc != 7'd100);
    assign n_s0_y    = i_yoc - 7'd1;

    always_comb begin
        if (i_yoc == 7'd0) begin
            n_s0_base = -18'sd366;
        end else begin
            n_s0_base = $signed(18'(18'(n_s0_y) * 18'(ecc_pkg::DAYS_1Y))
                        + 18'(n_s0_y[6:2]) - 18'(n_s0_y >= 7'd100));
        end
    end

    always_comb begin
        if (i_month == 4'd0) begin
            n_s0_limit = 4'd0;
        end else if (i_month > 4'd12) begin
            n_s0_limit = 4'd12;
        end else begin
            n_s0_limit = i_month - 4'd1;
        end
    end

    assign n_s0_start = ecc_pkg::month_start(n_s0_leap, n_s0_limit);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s0_day <= n_s0_base + $signed({9'd0, n_s0_start})
                        + $signed({13'd0, i_mday}) - 18'sd1;
            r_s0_tod <= 17'(i_hour) * 17'(ecc_pkg::SECS_PER_HOUR)
                        + 17'(i_minute) * 17'(ecc_pkg::SECS_PER_MIN) + 17'(i_second);
            r_s0_k   <= 32'(ecc_pkg::EPOCH_2001) - {{15{i_offset[16]}}, i_offset};
        end
    end

    // stage 1: days to seconds, wrapping
    logic [31:0] n_s1_p;
    logic [31:0] r_s1_p;
    logic [31:0] r_s1_s;

    assign n_s1_p = {{14{r_s0_day[17]}}, r_s0_day} * 32'(ecc_pkg::SECS_PER_DAY);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s1_p <= n_s1_p;
            r_s1_s <= 32'(r_s0_tod) + r_s0_k;
        end
    end

    // stage 2 sums, later stages only keep step with the decoder
    logic [31:0] r_sec [2:LAST];

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_sec[2] <= r_s1_p + r_s1_s;
        end
        for (int k = 3; k <= LAST; k++) begin
            if (i_en[k]) begin
                r_sec[k] <= r_sec[k-1];
            end
        end
    end

    assign o_seconds = r_sec[LAST];

endmodule

/* sv/epoch_calendar_converter.sv */
// epoch_calendar_converter: two-way unix seconds / local calendar converter
// depends on ecc_pkg, ecc_dec and ecc_enc
//
// usage
//   input channel i_valid / o_ready carries one word: mode plus both payloads.
//   mode 0 decodes i_epoch_seconds_in into local calendar fields, mode 1
//   encodes the calendar inputs into unix seconds; unused result fields read 0.
//   output channel o_valid / i_ready carries one result word per input word,
//   in order.
//   zone offset is written through i_cfg_we / i_cfg_data (17 bit two's
//   complement seconds, reset value 28800); the user must write it only
//   while no word is in flight, the block itself does not enforce this.
//   each word passes nine register stages of the decode datapath, the first
//   loaded at acceptance (the encode path runs in step with it).
//   throughput is one word per cycle while the receiver keeps i_ready high.
//   when the receiver stalls, each stage holds its word and empty stages keep
//   filling, so up to 9 words are held before o_ready drops.
//   synchronous active-low reset empties the pipeline and restores the offset.
module epoch_calendar_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [31:0] i_epoch_seconds_in,
    input  logic [6:0]  i_year_of_century_in,
    input  logic [3:0]  i_month_in,
    input  logic [4:0]  i_day_in,
    input  logic [4:0]  i_hour_in,
    input  logic [5:0]  i_minute_in,
    input  logic [5:0]  i_second_in,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_epoch_seconds_out,
    output logic [6:0]  o_year_of_century_out,
    output logic [3:0]  o_month_out,
    output logic [4:0]  o_day_out,
    output logic [4:0]  o_hour_out,
    output logic [5:0]  o_minute_out,
    output logic [5:0]  o_second_out,
    output logic [2:0]  o_weekday_out
);

    localparam int LAST = ecc_pkg::STAGES - 1;

    logic [16:0]               r_zone;
    logic [LAST:0]             r_vld;
    logic [LAST:0]             r_mode;
    logic [LAST:0]             n_en;
    ecc_pkg::t_cal             w_cal;
    logic [31:0]               w_seconds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= ecc_pkg::ZONE_RESET;
        end else if (i_cfg_we) begin
            r_zone <= i_cfg_data;
        end
    end

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        n_en[LAST] = !r_vld[LAST] || i_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            n_en[k] = !r_vld[k] || n_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (n_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en[0]) begin
            r_mode[0] <= i_mode;
        end
        for (int k = 1; k <= LAST; k++) begin
            if (n_en[k]) begin
                r_mode[k] <= r_mode[k-1];
            end
        end
    end

    ecc_dec u_dec (
        .i_clk    (i_clk),
        .i_en     (n_en),
        .i_epoch  (i_epoch_seconds_in),
        .i_offset (r_zone),
        .o_cal    (w_cal)
    );

    ecc_enc u_enc (
        .i_clk     (i_clk),
        .i_en      (n_en),
        .i_yoc     (i_year_of_century_in),
        .i_month   (i_month_in),
        .i_mday    (i_day_in),
        .i_hour    (i_hour_in),
        .i_minute  (i_minute_in),
        .i_second  (i_second_in),
        .i_offset  (r_zone),
        .o_seconds (w_seconds)
    );

    assign o_ready = n_en[0];
    assign o_valid = r_vld[LAST];

    assign o_epoch_seconds_out   = r_mode[LAST] ? w_seconds : 32'd0;
    assign o_year_of_century_out = r_mode[LAST] ? 7'd0 : w_cal.yoc;
    assign o_month_out           = r_mode[LAST] ? 4'd0 : w_cal.month;
    assign o_day_out             = r_mode[LAST] ? 5'd0 : w_cal.mday;
    assign o_hour_out            = r_mode[LAST] ? 5'd0 : w_cal.hour;
    assign o_minute_out          = r_mode[LAST] ? 6'd0 : w_cal.minute;
    assign o_second_out          = r_mode[LAST] ? 6'd0 : w_cal.second;
    assign o_weekday_out         = r_mode[LAST] ? 3'd0 : w_cal.wday;

`ifndef SYNTHESIS
    // a hole anywhere in the pipeline means a new word can enter
    a_ready_when_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(&r_vld) |-> o_ready)
        else $error("input stalled with an empty stage");

    a_decode_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_mode[LAST]) |-> (o_month_out >= 4'd1 && o_month_out <= 4'd12
            && o_day_out >= 5'd1 && o_year_of_century_out <= 7'd99))
        else $error("decoded date out of range");

    a_decode_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_mode[LAST]) |-> (o_hour_out <= 5'd23 && o_minute_out <= 6'd59
            && o_second_out <= 6'd59 && o_weekday_out >= 3'd1 && o_weekday_out <= 3'd7))
        else $error("decoded time or weekday out of range");

    a_encode_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_mode[LAST]) |-> (o_month_out == 4'd0 && o_day_out == 5'd0
            && o_weekday_out == 3'd0))
        else $error("calendar fields not cleared on an encode word");
`endif

endmodule
